FILE: hdl/u8u16_pkg.sv
// Shared types, constants and decode helpers of the UTF-8 to UTF-16 transcoder.
`timescale 1ns / 1ps
`default_nettype none

package u8u16_pkg;

	// Job queue between front and back
	localparam int QueueDepth = 4;
	localparam int QueueAw    = $clog2(QueueDepth);
	localparam int QueueCntW  = $clog2(QueueDepth + 1);

	// Output codes
	localparam logic [15:0] BadUnit   = 16'h0023;
	localparam logic [5:0]  SurHiTag  = 6'b110110;
	localparam logic [5:0]  SurLoTag  = 6'b110111;
	localparam logic [20:0] MaxCp     = 21'h10FFFF;

	// One decode job: up to four bytes, lead first, in byte lanes 0..3
	typedef struct packed {
		logic [31:0] data;
		logic [1:0]  n_m1;   // byte count minus one
		logic        last;   // job closes the text
	} job_t;

	// Sequence length from the top five bits of a lead byte, 0 for invalid
	function automatic logic [2:0] seq_len(input logic [7:0] b);
		logic [2:0] l;
		l = 3'd0;
		case (b[7:3])
			5'b11000, 5'b11001, 5'b11010, 5'b11011: l = 3'd2;
			5'b11100, 5'b11101:                     l = 3'd3;
			5'b11110:                               l = 3'd4;
			default: begin
				if (!b[7]) l = 3'd1;
				else       l = 3'd0;
			end
		endcase
		return l;
	endfunction

	// Code point from up to four bytes for a given valid length
	function automatic logic [20:0] seq_cp(input logic [2:0] l, input logic [7:0] b0,
		input logic [7:0] b1, input logic [7:0] b2, input logic [7:0] b3);
		logic [20:0] cp;
		cp = '0;
		case (l)
			3'd1:    cp = {14'd0, b0[6:0]};
			3'd2:    cp = {10'd0, b0[4:0], b1[5:0]};
			3'd3:    cp = {5'd0, b0[3:0], b1[5:0], b2[5:0]};
			3'd4:    cp = {b0[2:0], b1[5:0], b2[5:0], b3[5:0]};
			default: cp = '0;
		endcase
		return cp;
	endfunction

endpackage

`default_nettype wire

FILE: hdl/utf8_to_utf16_transcoder.sv
// Top level of the UTF-8 to UTF-16 transcoder.
// The block takes one UTF-8 byte per beat and emits UTF-16 code units, one per beat on the
// output. The front end accepts a byte every cycle while its four-entry job queue has room;
// it buffers the bytes of an open sequence and hands a whole sequence (or, on the final byte
// of the text, everything still buffered) to the back end as one job. The back end produces
// one code unit per cycle while the output is not stalled: one for a single-unit job, two for
// a surrogate pair and up to three for an end-of-text replay of a cut-off sequence. A job is
// registered in the queue, then each of its units in the output register. Invalid leads,
// cut-off leads and code points above 0x10FFFF come out as '#' (0x0023); run_last marks the
// last unit caused by a byte and text_end the last unit of the text.
`timescale 1ns / 1ps
`default_nettype none

module utf8_to_utf16_transcoder
	import u8u16_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	output logic             in_stall,
	input  wire logic [7:0]  in_byte,
	input  wire logic        in_last,
	output logic             out_valid,
	input  wire logic        out_stall,
	output logic [15:0]      code_unit,
	output logic             run_last,
	output logic             text_end
);

	logic q_full;
	logic push;
	job_t push_job;
	logic head_valid;
	job_t head_job;
	logic pop;

	u8u16_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.in_byte  (in_byte),
		.in_last  (in_last),
		.q_full   (q_full),
		.push     (push),
		.push_job (push_job)
	);

	u8u16_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_job   (push_job),
		.full       (q_full),
		.head_valid (head_valid),
		.head_job   (head_job),
		.pop        (pop)
	);

	u8u16_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.job_valid (head_valid),
		.job       (head_job),
		.pop       (pop),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.code_unit (code_unit),
		.run_last  (run_last),
		.text_end  (text_end)
	);

endmodule

`default_nettype wire

FILE: hdl/u8u16_front.sv
// Front end: takes bytes, gathers open sequences and issues decode jobs.
`timescale 1ns / 1ps
`default_nettype none

module u8u16_front
	import u8u16_pkg::*;
(
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       in_valid,
	output logic            in_stall,
	input  wire logic [7:0] in_byte,
	input  wire logic       in_last,
	input  wire logic       q_full,
	output logic            push,
	output job_t            push_job
);

	logic [2:0][7:0] pend_q;
	logic [1:0]      pend_cnt_q;
	logic [2:0]      exp_len_q;

	logic            accept;
	logic [2:0]      lead_len;
	logic [3:0][7:0] word;
	logic [2:0]      cnt_new;
	logic            issue;
	logic            open_seq;

	assign in_stall = q_full;
	assign accept   = in_valid && !in_stall;
	assign lead_len = seq_len(in_byte);
	assign cnt_new  = {1'b0, pend_cnt_q} + 3'd1;

	// Buffered bytes with the new beat appended
	always_comb begin
		word             = {8'h00, pend_q};
		word[pend_cnt_q] = in_byte;
	end

	// Decide between buffering and issuing a job
	always_comb begin
		issue    = 1'b0;
		open_seq = 1'b0;
		if (in_last) begin
			issue = 1'b1;
		end else if (exp_len_q == 3'd0) begin
			if (lead_len <= 3'd1) issue = 1'b1;
			else                  open_seq = 1'b1;
		end else if (cnt_new >= exp_len_q) begin
			issue = 1'b1;
		end
	end

	assign push          = accept && issue;
	assign push_job.data = word;
	assign push_job.n_m1 = pend_cnt_q;
	assign push_job.last = in_last;

	// Open sequence state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_cnt_q <= '0;
			exp_len_q  <= '0;
		end else if (accept) begin
			if (issue) begin
				pend_cnt_q <= '0;
				exp_len_q  <= '0;
			end else if (open_seq) begin
				pend_cnt_q <= 2'd1;
				exp_len_q  <= lead_len;
			end else begin
				pend_cnt_q <= cnt_new[1:0];
			end
		end
	end

	// Byte buffer, payload only
	always_ff @(posedge clk) begin
		if (accept && !issue) begin
			if (open_seq) pend_q[0] <= in_byte;
			else          pend_q[pend_cnt_q] <= in_byte;
		end
	end

	a_idle_empty: assert property (@(posedge clk) disable iff (!arst_n)
		exp_len_q == 3'd0 |-> pend_cnt_q == 2'd0)
		else $error("front: bytes buffered with no open sequence");

	a_open_short: assert property (@(posedge clk) disable iff (!arst_n)
		exp_len_q != 3'd0 |-> pend_cnt_q != 2'd0 && {1'b0, pend_cnt_q} < exp_len_q)
		else $error("front: open sequence count out of range");

	a_last_clears: assert property (@(posedge clk) disable iff (!arst_n)
		accept && in_last |=> exp_len_q == 3'd0 && pend_cnt_q == 2'd0)
		else $error("front: state not cleared after final beat");

endmodule

`default_nettype wire

FILE: hdl/u8u16_queue.sv
// Short job queue between front and back ends.
`timescale 1ns / 1ps
`default_nettype none

module u8u16_queue
	import u8u16_pkg::*;
(
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic push,
	input  job_t      push_job,
	output logic      full,
	output logic      head_valid,
	output job_t      head_job,
	input  wire logic pop
);

	job_t                 mem [QueueDepth];
	logic [QueueAw-1:0]   wr_ptr_q;
	logic [QueueAw-1:0]   rd_ptr_q;
	logic [QueueCntW-1:0] cnt_q;

	assign full       = cnt_q == QueueCntW'(QueueDepth);
	assign head_valid = cnt_q != '0;
	assign head_job   = mem[rd_ptr_q];

	// Pointers and fill level
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) wr_ptr_q <= wr_ptr_q + QueueAw'(1);
			if (pop)  rd_ptr_q <= rd_ptr_q + QueueAw'(1);
			case ({push, pop})
				2'b10:   cnt_q <= cnt_q + QueueCntW'(1);
				2'b01:   cnt_q <= cnt_q - QueueCntW'(1);
				default: cnt_q <= cnt_q;
			endcase
		end
	end

	// Storage
	always_ff @(posedge clk) begin
		if (push) mem[wr_ptr_q] <= push_job;
	end

endmodule

`default_nettype wire

FILE: hdl/u8u16_back.sv
// Back end: decodes each job, one UTF-16 unit per unstalled cycle, to the output register.
`timescale 1ns / 1ps
`default_nettype none

module u8u16_back
	import u8u16_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        job_valid,
	input  job_t             job,
	output logic             pop,
	output logic             out_valid,
	input  wire logic        out_stall,
	output logic [15:0]      code_unit,
	output logic             run_last,
	output logic             text_end
);

	logic [1:0]  pos_q;
	logic        half_q;
	logic        out_valid_q;
	logic [15:0] unit_q;
	logic        run_last_q;
	logic        text_end_q;

	logic        out_ready;
	logic        step;
	logic [31:0] shifted;
	logic [7:0]  sb0, sb1, sb2, sb3;
	logic [2:0]  l;
	logic [2:0]  seq_end;
	logic [2:0]  job_cnt;
	logic        bad;
	logic [2:0]  adv;
	logic        fin;
	logic [20:0] cp;
	logic [19:0] v;
	logic        pair;
	logic        seq_done;
	logic [15:0] unit;

	assign out_ready = !out_valid_q || !out_stall;
	assign step      = job_valid && out_ready;

	// Bytes of the sequence at the current position
	assign shifted = job.data >> {pos_q, 3'b000};
	assign sb0     = shifted[7:0];
	assign sb1     = shifted[15:8];
	assign sb2     = shifted[23:16];
	assign sb3     = shifted[31:24];

	// Length check against the bytes left in the job
	assign l       = seq_len(sb0);
	assign job_cnt = {1'b0, job.n_m1} + 3'd1;
	assign seq_end = {1'b0, pos_q} + l;
	assign bad     = (l == 3'd0) || (seq_end > job_cnt);
	assign adv     = bad ? 3'd1 : l;
	assign fin     = ({1'b0, pos_q} + adv) == job_cnt;

	// Code point and unit selection
	assign cp = seq_cp(l, sb0, sb1, sb2, sb3);
	assign v  = 20'(cp - 21'h010000);

	always_comb begin
		pair = 1'b0;
		unit = BadUnit;
		if (bad || cp > MaxCp) begin
			unit = BadUnit;
		end else if (cp[20:16] != 5'd0) begin
			pair = 1'b1;
			unit = half_q ? {SurLoTag, v[9:0]} : {SurHiTag, v[19:10]};
		end else begin
			unit = cp[15:0];
		end
	end

	assign seq_done = !pair || half_q;
	assign pop      = step && seq_done && fin;

	// Sequencer over the job
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q  <= '0;
			half_q <= 1'b0;
		end else if (step) begin
			if (!seq_done) begin
				half_q <= 1'b1;
			end else begin
				half_q <= 1'b0;
				if (fin) pos_q <= '0;
				else     pos_q <= pos_q + adv[1:0];
			end
		end
	end

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (step) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (step) begin
			unit_q     <= unit;
			run_last_q <= seq_done && fin;
			text_end_q <= seq_done && fin && job.last;
		end
	end

	assign out_valid = out_valid_q;
	assign code_unit = unit_q;
	assign run_last  = run_last_q;
	assign text_end  = text_end_q;

	a_half_has_job: assert property (@(posedge clk) disable iff (!arst_n)
		half_q |-> job_valid && pair)
		else $error("back: low surrogate pending without its job");

	a_pos_in_job: assert property (@(posedge clk) disable iff (!arst_n)
		job_valid |-> pos_q <= job.n_m1)
		else $error("back: position beyond job bytes");

	a_idle_pos: assert property (@(posedge clk) disable iff (!arst_n)
		!job_valid |-> pos_q == 2'd0 && !half_q)
		else $error("back: sequencer not at rest with no job");

endmodule

`default_nettype wire

FILE: dv/tb_utf8_to_utf16_transcoder.sv
// Self-checking testbench for the UTF-8 to UTF-16 transcoder: directed table, then random texts.
`timescale 1ns / 1ps

module tb_utf8_to_utf16_transcoder;
	import u8u16_pkg::BadUnit;

	// One expected code unit with its markers
	typedef struct packed {
		logic [15:0] code;
		logic        run_last;
		logic        text_end;
	} utf16_unit_t;

	// Directed row: byte, last flag, and optionally the units typed in by hand
	typedef struct packed {
		logic [7:0]  b;
		logic        last;
		logic        typed;
		logic [1:0]  n;
		logic [15:0] u0;
		logic [15:0] u1;
	} dir_row_t;

	localparam int NumDirRows = 24;

	logic        clk;
	logic        arst_n    = 1'b0;
	logic        in_valid  = 1'b0;
	logic        in_stall;
	logic [7:0]  in_byte   = 8'h00;
	logic        in_last   = 1'b0;
	logic        out_valid;
	logic        out_stall = 1'b0;
	logic [15:0] code_unit;
	logic        run_last;
	logic        text_end;

	// Units still to come from the block, oldest first
	utf16_unit_t utf16_due [$];
	// Units worked out for the byte just accepted
	logic [15:0] step_codes [$];
	// Bytes of the random text being built
	logic [7:0]  text_bytes [$];

	// Transcoder state kept alongside the block
	logic [7:0]  held [3];
	int unsigned held_cnt  = 0;
	int unsigned seq_want  = 0;
	logic [7:0]  window [4];

	int          send_idle_pct = 0;
	int          stall_pct     = 0;
	int          hold_left     = 0;
	int          sent          = 0;
	int          mismatches    = 0;

	dir_row_t dir_rows [NumDirRows] = '{
		// after reset, both ends of the byte range, continuation as lead
		'{8'h00, 1'b0, 1'b1, 2'd1, 16'h0000, 16'h0000},
		'{8'hFF, 1'b0, 1'b1, 2'd1, BadUnit,  16'h0000},
		'{8'h80, 1'b0, 1'b1, 2'd1, BadUnit,  16'h0000},
		// overlong zero passes through
		'{8'hC0, 1'b0, 1'b0, 2'd0, 16'h0000, 16'h0000},
		'{8'h80, 1'b0, 1'b0, 2'd0, 16'h0000, 16'h0000},
		// encoded surrogate passes through
		'{8'hED, 1'b0, 1'b0, 2'd0, 16'h0000, 16'h0000},
		'{8'hA0, 1'b0, 1'b0, 2'd0, 16'h0000, 16'h0000},
		'{8'h80, 1'b0, 1'b0, 2'd0, 16'h0000, 16'h0000},
		// highest code point, surrogate pair
		'{8'hF4, 1'b0, 1'b0, 2'd0, 16'h0000, 16'h0000},
		'{8'h8F, 1'b0, 1'b0, 2'd0, 16'h0000, 16'h0000},
		'{8'hBF, 1'b0, 1'b0, 2'd0, 16'h0000, 16'h0000},
		'{8'hBF, 1'b0, 1'b0, 2'd0, 16'h0000, 16'h0000},
		// above range
		'{8'hF7, 1'b0, 1'b0, 2'd0, 16'h0000, 16'h0000},
		'{8'hBF, 1'b0, 1'b0, 2'd0, 16'h0000, 16'h0000},
		'{8'hBF, 1'b0, 1'b0, 2'd0, 16'h0000, 16'h0000},
		'{8'hBF, 1'b0, 1'b1, 2'd1, BadUnit,  16'h0000},
		// cut off by end of text: lead and lone continuation both bad
		'{8'hE2, 1'b0, 1'b0, 2'd0, 16'h0000, 16'h0000},
		'{8'h82, 1'b1, 1'b1, 2'd2, BadUnit,  BadUnit},
		// cut off, tail decodes again as a two-byte sequence
		'{8'hF0, 1'b0, 1'b0, 2'd0, 16'h0000, 16'h0000},
		'{8'hC3, 1'b0, 1'b0, 2'd0, 16'h0000, 16'h0000},
		'{8'hA9, 1'b1, 1'b0, 2'd0, 16'h0000, 16'h0000},
		// single-byte texts
		'{8'h7F, 1'b1, 1'b1, 2'd1, 16'h007F, 16'h0000},
		'{8'hFF, 1'b1, 1'b1, 2'd1, BadUnit,  16'h0000},
		'{8'hC3, 1'b1, 1'b1, 2'd1, BadUnit,  16'h0000}
	};

	utf8_to_utf16_transcoder u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.in_byte   (in_byte),
		.in_last   (in_last),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.code_unit (code_unit),
		.run_last  (run_last),
		.text_end  (text_end)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	// Sequence length from the lead byte, 0 when it cannot start one
	function automatic int unsigned lead_len(input logic [7:0] b);
		casez (b)
			8'b0???????: return 1;
			8'b110?????: return 2;
			8'b1110????: return 3;
			8'b11110???: return 4;
			default:     return 0;
		endcase
	endfunction

	// Code point to one unit, a surrogate pair, or '#' above the range
	function automatic void emit_cp(input logic [20:0] cp);
		logic [20:0] v;
		if (cp > 21'h10FFFF) begin
			step_codes.push_back(BadUnit);
		end else if (cp >= 21'h10000) begin
			v = cp - 21'h10000;
			step_codes.push_back(16'hD800 + {6'd0, v[19:10]});
			step_codes.push_back(16'hDC00 + {6'd0, v[9:0]});
		end else begin
			step_codes.push_back(cp[15:0]);
		end
	endfunction

	// Decode one sequence at pos with cap bytes left; returns bytes used
	function automatic int unsigned decode_at(input int unsigned pos, input int unsigned cap);
		int unsigned len;
		int unsigned i;
		logic [20:0] cp;
		len = lead_len(window[pos]);
		if (len == 0 || len > cap) begin
			step_codes.push_back(BadUnit);
			return 1;
		end
		case (len)
			1:       cp = {14'd0, window[pos][6:0]};
			2:       cp = {16'd0, window[pos][4:0]};
			3:       cp = {17'd0, window[pos][3:0]};
			default: cp = {18'd0, window[pos][2:0]};
		endcase
		for (i = 1; i < len; i++)
			cp = (cp << 6) | {15'd0, window[pos + i][5:0]};
		emit_cp(cp);
		return len;
	endfunction

	// Units caused by one accepted byte; updates the held sequence
	function automatic void transcode_byte(input logic [7:0] b, input logic last);
		int unsigned cnt;
		int unsigned pos;
		int unsigned len;
		int unsigned i;
		step_codes.delete();
		for (i = 0; i < held_cnt; i++)
			window[i] = held[i];
		window[held_cnt] = b;
		cnt = held_cnt + 1;
		if (last) begin
			// end of text: replay everything held, each sequence limited to what remains
			pos = 0;
			while (pos < cnt)
				pos += decode_at(pos, cnt - pos);
			held_cnt = 0;
			seq_want = 0;
		end else if (seq_want == 0) begin
			len = lead_len(b);
			if (len <= 1) begin
				void'(decode_at(0, 1));
			end else begin
				held[0]  = b;
				held_cnt = 1;
				seq_want = len;
			end
		end else if (cnt >= seq_want) begin
			void'(decode_at(0, cnt));
			held_cnt = 0;
			seq_want = 0;
		end else begin
			held[held_cnt] = b;
			held_cnt       = cnt;
		end
	endfunction

	// Offer one byte, wait for the beat, then queue what it should produce
	task automatic send_byte(input logic [7:0] b, input logic last, input logic typed,
		input logic [1:0] n, input logic [15:0] u0, input logic [15:0] u1);
		utf16_unit_t u;
		int          i;
		while ($urandom_range(0, 99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		in_byte  <= b;
		in_last  <= last;
		do
			@(posedge clk);
		while (in_stall);
		sent++;
		transcode_byte(b, last);
		if (typed) begin
			step_codes.delete();
			step_codes.push_back(u0);
			if (n == 2'd2)
				step_codes.push_back(u1);
		end
		for (i = 0; i < step_codes.size(); i++) begin
			u.code     = step_codes[i];
			u.run_last = (i == step_codes.size() - 1);
			u.text_end = u.run_last && last;
			utf16_due.push_back(u);
		end
	endtask

	// Continuation byte, now and then with a wrong marker since the block does not check it
	function automatic logic [7:0] cont(input logic [5:0] bits);
		logic [1:0] top;
		top = ($urandom_range(0, 9) == 0) ? 2'($urandom_range(0, 3)) : 2'b10;
		return {top, bits};
	endfunction

	// Append one sequence, mostly well formed, sometimes a raw noise byte
	task automatic append_seq();
		logic [20:0] cp;
		if ($urandom_range(0, 99) < 15) begin
			text_bytes.push_back(8'($urandom_range(0, 255)));
			return;
		end
		case ($urandom_range(0, 3))
			0: begin
				cp = 21'($urandom_range(0, 'h7F));
				text_bytes.push_back({1'b0, cp[6:0]});
			end
			1: begin
				cp = 21'($urandom_range(0, 'h7FF));
				text_bytes.push_back({3'b110, cp[10:6]});
				text_bytes.push_back(cont(cp[5:0]));
			end
			2: begin
				cp = 21'($urandom_range(0, 'hFFFF));
				text_bytes.push_back({4'b1110, cp[15:12]});
				text_bytes.push_back(cont(cp[11:6]));
				text_bytes.push_back(cont(cp[5:0]));
			end
			default: begin
				if ($urandom_range(0, 3) == 0)
					cp = 21'($urandom_range(0, 'h1FFFFF));
				else
					cp = 21'($urandom_range('h10000, 'h10FFFF));
				text_bytes.push_back({5'b11110, cp[20:18]});
				text_bytes.push_back(cont(cp[17:12]));
				text_bytes.push_back(cont(cp[11:6]));
				text_bytes.push_back(cont(cp[5:0]));
			end
		endcase
	endtask

	// Random text; about a quarter of those over two bytes lose one or two tail bytes, so the end may cut a sequence
	task automatic send_text();
		int k;
		int i;
		text_bytes.delete();
		k = $urandom_range(1, 6);
		repeat (k) append_seq();
		if ($urandom_range(0, 3) == 0 && text_bytes.size() > 2)
			repeat ($urandom_range(1, 2)) void'(text_bytes.pop_back());
		for (i = 0; i < text_bytes.size(); i++)
			send_byte(text_bytes[i], i == text_bytes.size() - 1, 1'b0, 2'd0, 16'h0, 16'h0);
	endtask

	task automatic run_random(input int beats);
		int target;
		target = sent + beats;
		while (sent < target)
			send_text();
	endtask

	// Receiver: long hold when asked, otherwise random stalls
	initial begin
		forever begin
			@(posedge clk);
			if (hold_left > 0) begin
				out_stall <= 1'b1;
				hold_left--;
			end else begin
				out_stall <= ($urandom_range(0, 99) < stall_pct);
			end
		end
	end

	// Output check against the oldest expected unit
	always @(posedge clk) begin
		utf16_unit_t exp_u;
		if (arst_n && out_valid && !out_stall) begin
			if (utf16_due.size() == 0) begin
				mismatches++;
				$display("%0t: unexpected unit %h (run_last %b text_end %b)",
					$time, code_unit, run_last, text_end);
			end else begin
				exp_u = utf16_due.pop_front();
				if (code_unit !== exp_u.code) begin
					mismatches++;
					$display("%0t: code_unit expected %h got %h", $time, exp_u.code, code_unit);
				end
				if (run_last !== exp_u.run_last) begin
					mismatches++;
					$display("%0t: run_last expected %b got %b", $time, exp_u.run_last, run_last);
				end
				if (text_end !== exp_u.text_end) begin
					mismatches++;
					$display("%0t: text_end expected %b got %b", $time, exp_u.text_end, text_end);
				end
			end
		end
	end

	// Hard limit on the run
	initial begin
		#200000;
		$display("tb_utf8_to_utf16_transcoder: done, errors");
		$finish;
	end

	// Main sequence
	initial begin
		int r;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed table, no idling
		for (r = 0; r < NumDirRows; r++)
			send_byte(dir_rows[r].b, dir_rows[r].last, dir_rows[r].typed, dir_rows[r].n,
				dir_rows[r].u0, dir_rows[r].u1);

		// long receiver hold while bytes keep coming, to back the block up
		hold_left = 80;
		run_random(75);

		send_idle_pct = 56;
		stall_pct     = 0;
		run_random(75);

		send_idle_pct = 0;
		stall_pct     = 56;
		run_random(75);

		send_idle_pct = 9;
		stall_pct     = 9;
		run_random(75);

		in_valid <= 1'b0;
		while (utf16_due.size() != 0)
			@(posedge clk);
		repeat (16) @(posedge clk);

		if (mismatches == 0)
			$display("tb_utf8_to_utf16_transcoder: done, clean");
		else
			$display("tb_utf8_to_utf16_transcoder: done, errors");
		$finish;
	end

endmodule
